// ----- design/im2c_pkg.sv -----
// Shared types, widths, register codes and the stride reciprocal table.
package im2c_pkg;

    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_REG_W   = 13;
    localparam int KER_REG_W   = 4;
    localparam int PAD_REG_W   = 3;
    localparam int STR_REG_W   = 4;
    localparam int IDX_W       = 24;
    localparam int LIMIT_W     = 25;
    localparam int BASE_W      = 32;
    localparam int OUT_ADDR_W  = 32;
    localparam int SPAN_W      = DIM_REG_W + 1;
    localparam int GRID_W      = SPAN_W;
    localparam int PLANE_W     = 2 * GRID_W;
    localparam int KK_W        = 2 * KER_REG_W;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int OFS_W       = GRID_W + STR_REG_W + 2;
    localparam int DIV_STEP    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int GEOM_LAT    = 4;

    localparam int DEF_MAX_KERNEL = 8;
    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd7;

    typedef struct packed {
        logic [DIM_REG_W-1:0] image_height;
        logic [DIM_REG_W-1:0] image_width;
        logic [KER_REG_W-1:0] kernel_height;
        logic [KER_REG_W-1:0] kernel_width;
        logic [PAD_REG_W-1:0] pad_rows;
        logic [PAD_REG_W-1:0] pad_cols;
        logic [STR_REG_W-1:0] stride_rows;
        logic [STR_REG_W-1:0] stride_cols;
    } cfg_t;

    typedef struct packed {
        logic               ready;
        logic               ok;
        logic [GRID_W-1:0]  out_h;
        logic [GRID_W-1:0]  out_w;
        logic [PLANE_W-1:0] plane;
        logic [KK_W-1:0]    taps;
    } geom_t;

    function automatic logic [RECIP_W-1:0] stride_recip(input logic [STR_REG_W-1:0] s);
        logic [RECIP_W-1:0] r;
        begin
            case (s)
                4'd1:    r = 17'd65536;
                4'd2:    r = 17'd32768;
                4'd3:    r = 17'd21845;
                4'd4:    r = 17'd16384;
                4'd5:    r = 17'd13107;
                4'd6:    r = 17'd10922;
                4'd7:    r = 17'd9362;
                4'd8:    r = 17'd8192;
                4'd9:    r = 17'd7281;
                4'd10:   r = 17'd6553;
                4'd11:   r = 17'd5957;
                4'd12:   r = 17'd5461;
                4'd13:   r = 17'd5041;
                4'd14:   r = 17'd4681;
                4'd15:   r = 17'd4369;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- design/im2c_idx_if.sv -----
// Index channel: flat output position and batch base addresses.
interface im2c_idx_if;
    import im2c_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   flat_index;
    logic [LIMIT_W-1:0] item_limit;
    logic [BASE_W-1:0]  image_base;
    logic [BASE_W-1:0]  column_base;

    modport source (output valid, flat_index, item_limit, image_base, column_base,
                    input ready);
    modport sink   (input valid, flat_index, item_limit, image_base, column_base,
                    output ready);
endinterface

// ----- design/im2c_addr_if.sv -----
// Address channel: one source/destination pair per kernel tap.
interface im2c_addr_if;
    import im2c_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OUT_ADDR_W-1:0] source_address;
    logic [OUT_ADDR_W-1:0] dest_address;
    logic                  is_padding;
    logic                  last_tap;

    modport source (output valid, source_address, dest_address, is_padding, last_tap,
                    input ready);
    modport sink   (input valid, source_address, dest_address, is_padding, last_tap,
                    output ready);
endinterface

// ----- design/im2c_div.sv -----
// Multi-bit-per-cycle restoring divider for splitting the flat index.
module im2c_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 14,
    parameter int STEP  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int NSTEP = (DVD_W + STEP - 1) / STEP;
    localparam int PAD_W = NSTEP * STEP;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic [PAD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PAD_W-1:0] q;
    logic [DVS_W-1:0] r;
    logic [DVS_W:0]   t;

    always_comb
    begin
        q = quot_reg;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < STEP; k++)
        begin
            t = {r, q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg})
            begin
                t    = t - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
            r = t[DVS_W-1:0];
        end
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = PAD_W'(dividend);
            rem_next  = '0;
            cnt_next  = CNT_W'(NSTEP);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = q;
            rem_next  = r;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg[DVD_W-1:0];
    assign remainder = rem_reg;
endmodule

// ----- design/im2c_front.sv -----
// Front end: accept an index, drop it or split it and compute the first tap addresses.
module im2c_front #(
    parameter int ADDR_WIDTH = 32,
    parameter int ENTRY_W    = 2 * 32 + 2 * 20
) (
    input  logic                clk,
    input  logic                rst_n,
    im2c_idx_if.sink            index_ch,
    input  im2c_pkg::cfg_t      cfg,
    input  im2c_pkg::geom_t     geom,
    output logic                push_valid,
    output logic [ENTRY_W-1:0]  push_data,
    input  logic                push_full
);
    import im2c_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_MUL3 = 3'd6;
    localparam logic [2:0] S_PUSH = 3'd7;

    localparam int CHIH_W = IDX_W + DIM_REG_W;
    localparam int RS_W   = GRID_W + STR_REG_W;
    localparam int DM_W   = IDX_W + KK_W;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] src;
        logic [ADDR_WIDTH-1:0] dst;
        logic [OFS_W-1:0]      hstart;
        logic [OFS_W-1:0]      wstart;
    } entry_t;

    logic [2:0]                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [BASE_W-1:0]         ibase_reg, cbase_reg;
    logic [GRID_W-1:0]         col_reg, row_reg;
    logic [IDX_W-1:0]          ch_reg;
    logic [ADDR_WIDTH-1:0]     chih_reg, hline_reg, srcoff_reg;
    logic [RS_W-1:0]           rsr_reg, csc_reg;
    logic [PLANE_W-1:0]        pos_reg;
    logic signed [OFS_W-1:0]   hstart_reg, wstart_reg;
    logic [DM_W-1:0]           dstmul_reg;
    logic [CHIH_W-1:0]         chih_full;
    logic signed [OFS_W-1:0]   hstart_calc;
    logic [IDX_W-1:0]          dm_base;

    logic                      div_start, div_done;
    logic [IDX_W-1:0]          div_dividend, div_quot;
    logic [GRID_W-1:0]         div_divisor, div_rem;
    entry_t                    entry;

    im2c_div #(.DVD_W(IDX_W), .DVS_W(GRID_W), .STEP(DIV_STEP)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign chih_full   = CHIH_W'(ch_reg) * CHIH_W'(cfg.image_height);
    assign hstart_calc = $signed(OFS_W'(rsr_reg)) - $signed(OFS_W'(cfg.pad_rows));
    assign dm_base     = IDX_W'(idx_reg - IDX_W'(pos_reg));

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = idx_reg;
        div_divisor  = geom.out_w;
        case (state_reg)
            S_IDLE:
            begin
                if (index_ch.valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (geom.ready)
                begin
                    if (!geom.ok || (LIMIT_W'(idx_reg) >= limit_reg))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                div_dividend = div_quot;
                div_divisor  = geom.out_h;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_PUSH;
            S_PUSH:
            begin
                if (!push_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && index_ch.valid)
        begin
            idx_reg   <= index_ch.flat_index;
            limit_reg <= index_ch.item_limit;
            ibase_reg <= index_ch.image_base;
            cbase_reg <= index_ch.column_base;
        end
        if (state_reg == S_DIV1 && div_done)
        begin
            col_reg <= div_rem;
        end
        if (state_reg == S_DIV2 && div_done)
        begin
            row_reg <= div_rem;
            ch_reg  <= div_quot;
        end
        if (state_reg == S_MUL1)
        begin
            chih_reg <= ADDR_WIDTH'(chih_full);
            rsr_reg  <= RS_W'(row_reg) * RS_W'(cfg.stride_rows);
            csc_reg  <= RS_W'(col_reg) * RS_W'(cfg.stride_cols);
            pos_reg  <= PLANE_W'(row_reg) * PLANE_W'(geom.out_w);
        end
        if (state_reg == S_MUL2)
        begin
            hstart_reg <= hstart_calc;
            wstart_reg <= $signed(OFS_W'(csc_reg)) - $signed(OFS_W'(cfg.pad_cols));
            hline_reg  <= chih_reg + ADDR_WIDTH'(hstart_calc);
            pos_reg    <= pos_reg + PLANE_W'(col_reg);
        end
        if (state_reg == S_MUL3)
        begin
            srcoff_reg <= hline_reg * ADDR_WIDTH'(cfg.image_width);
            dstmul_reg <= DM_W'(dm_base) * DM_W'(geom.taps);
        end
    end

    always_comb
    begin
        entry.src    = ADDR_WIDTH'(ibase_reg) + srcoff_reg + ADDR_WIDTH'(wstart_reg);
        entry.dst    = ADDR_WIDTH'(cbase_reg) + ADDR_WIDTH'(dstmul_reg)
                       + ADDR_WIDTH'(pos_reg);
        entry.hstart = hstart_reg;
        entry.wstart = wstart_reg;
    end

    assign index_ch.ready = (state_reg == S_IDLE);
    assign push_valid     = (state_reg == S_PUSH);
    assign push_data      = ENTRY_W'(entry);
endmodule

// ----- design/im2c_queue.sv -----
// Small FIFO between the front and back ends.
module im2c_queue #(
    parameter int W     = 104,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end
endmodule

// ----- design/im2c_back.sv -----
// Back end: walk the kernel taps of a queued index and emit one address pair per cycle while addr_ch is ready.
module im2c_back #(
    parameter int ADDR_WIDTH = 32,
    parameter int ENTRY_W    = 2 * 32 + 2 * 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ENTRY_W-1:0]  pop_data,
    input  logic                empty,
    output logic                pop,
    input  im2c_pkg::cfg_t      cfg,
    input  im2c_pkg::geom_t     geom,
    im2c_addr_if.source         addr_ch
);
    import im2c_pkg::*;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] src;
        logic [ADDR_WIDTH-1:0] dst;
        logic [OFS_W-1:0]      hstart;
        logic [OFS_W-1:0]      wstart;
    } entry_t;

    entry_t                  e;
    logic                    active_reg, active_next;
    logic [KER_REG_W-1:0]    i_reg, i_next, j_reg, j_next;
    logic signed [OFS_W-1:0] hi_reg, hi_next, wi_reg, wi_next, wst_reg, wst_next;
    logic [ADDR_WIDTH-1:0]   src_reg, src_next, srow_reg, srow_next, dst_reg, dst_next;
    logic                    ovalid_reg, ovalid_next;
    logic [OUT_ADDR_W-1:0]   osrc_reg, osrc_next, odst_reg, odst_next;
    logic                    opad_reg, opad_next, olast_reg, olast_next;
    logic                    adv, emit, i_last, j_last, pad, load;

    assign e      = entry_t'(pop_data);
    assign adv    = !ovalid_reg || addr_ch.ready;
    assign emit   = active_reg && adv;
    assign i_last = (KER_REG_W'(i_reg + 1'b1) == cfg.kernel_height);
    assign j_last = (KER_REG_W'(j_reg + 1'b1) == cfg.kernel_width);
    assign load   = !empty && (!active_reg || (emit && i_last && j_last));
    assign pop    = load;
    assign pad    = (hi_reg < 0) || (wi_reg < 0)
                    || (hi_reg >= $signed(OFS_W'(cfg.image_height)))
                    || (wi_reg >= $signed(OFS_W'(cfg.image_width)));

    always_comb
    begin
        active_next = active_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        hi_next     = hi_reg;
        wi_next     = wi_reg;
        wst_next    = wst_reg;
        src_next    = src_reg;
        srow_next   = srow_reg;
        dst_next    = dst_reg;
        ovalid_next = ovalid_reg;
        osrc_next   = osrc_reg;
        odst_next   = odst_reg;
        opad_next   = opad_reg;
        olast_next  = olast_reg;
        if (adv)
        begin
            ovalid_next = emit;
        end
        if (emit)
        begin
            osrc_next  = pad ? '0 : OUT_ADDR_W'(src_reg);
            odst_next  = OUT_ADDR_W'(dst_reg);
            opad_next  = pad;
            olast_next = i_last && j_last;
            dst_next   = dst_reg + ADDR_WIDTH'(geom.plane);
            if (j_last)
            begin
                j_next    = '0;
                i_next    = i_reg + 1'b1;
                hi_next   = hi_reg + 1'b1;
                wi_next   = wst_reg;
                srow_next = srow_reg + ADDR_WIDTH'(cfg.image_width);
                src_next  = srow_reg + ADDR_WIDTH'(cfg.image_width);
            end
            else
            begin
                j_next   = j_reg + 1'b1;
                wi_next  = wi_reg + 1'b1;
                src_next = src_reg + 1'b1;
            end
            if (i_last && j_last)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            i_next      = '0;
            j_next      = '0;
            hi_next     = $signed(e.hstart);
            wi_next     = $signed(e.wstart);
            wst_next    = $signed(e.wstart);
            src_next    = e.src;
            srow_next   = e.src;
            dst_next    = e.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        hi_reg    <= hi_next;
        wi_reg    <= wi_next;
        wst_reg   <= wst_next;
        src_reg   <= src_next;
        srow_reg  <= srow_next;
        dst_reg   <= dst_next;
        osrc_reg  <= osrc_next;
        odst_reg  <= odst_next;
        opad_reg  <= opad_next;
        olast_reg <= olast_next;
    end

    assign addr_ch.valid          = ovalid_reg;
    assign addr_ch.source_address = osrc_reg;
    assign addr_ch.dest_address   = odst_reg;
    assign addr_ch.is_padding     = opad_reg;
    assign addr_ch.last_tap       = olast_reg;
endmodule

// ----- design/im2col_address_generator_unit.sv -----
// Top level of the im2col address generator: configuration, output grid and the two ends.
//
// Each accepted flat index yields kernel_height*kernel_width address pairs, one per
// cycle while the address channel accepts them, in row-major tap order; an index at or
// beyond item_limit, or any setting that leaves no valid grid, yields nothing. The front
// end takes no new index until it has split the current one by its two 8-bit-per-cycle
// divisions, by the output width and then the output height, and pushed it; a two-entry
// queue lets it run ahead of the tap walker. After a configuration write the front end
// waits for the output grid to settle before the next index is classified.
module im2col_address_generator_unit #(
    parameter int MAX_KERNEL = im2c_pkg::DEF_MAX_KERNEL,
    parameter int MAX_DIM    = im2c_pkg::DEF_MAX_DIM,
    parameter int ADDR_WIDTH = im2c_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2c_pkg::CFG_DATA_W-1:0] cfg_data,
    im2c_idx_if.sink                        index_ch,
    im2c_addr_if.source                     addr_ch
);
    import im2c_pkg::*;

    localparam int ENTRY_W = 2 * ADDR_WIDTH + 2 * OFS_W;
    localparam int PROD_W  = SPAN_W + RECIP_W;
    localparam int CORR_W  = GRID_W + STR_REG_W;
    localparam int SET_W   = $clog2(GEOM_LAT + 1);

    cfg_t               cfg_reg, cfg_next;
    geom_t              geom;
    logic [SET_W-1:0]   settle_reg, settle_next;
    logic [SPAN_W-1:0]  span_h, span_w;
    logic [SPAN_W-1:0]  diff_h_reg, diff_w_reg, diff_h2_reg, diff_w2_reg;
    logic [PROD_W-1:0]  prod_h_reg, prod_w_reg;
    logic [GRID_W-1:0]  q0_h_reg, q0_w_reg, out_h_reg, out_w_reg;
    logic [CORR_W-1:0]  rem_h, rem_w;
    logic [PLANE_W-1:0] plane_reg;
    logic [KK_W-1:0]    taps_reg;
    logic               ok_reg, ok_next;

    logic               push_valid, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0] push_data, pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[DIM_REG_W-1:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[DIM_REG_W-1:0];
                REG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_data[KER_REG_W-1:0];
                REG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_data[KER_REG_W-1:0];
                REG_PAD_ROWS:      cfg_next.pad_rows      = cfg_data[PAD_REG_W-1:0];
                REG_PAD_COLS:      cfg_next.pad_cols      = cfg_data[PAD_REG_W-1:0];
                REG_STRIDE_ROWS:   cfg_next.stride_rows   = cfg_data[STR_REG_W-1:0];
                REG_STRIDE_COLS:   cfg_next.stride_cols   = cfg_data[STR_REG_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
        settle_next = settle_reg;
        if (cfg_we)
        begin
            settle_next = '0;
        end
        else if (settle_reg != SET_W'(GEOM_LAT))
        begin
            settle_next = settle_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height  <= DIM_REG_W'(32);
            cfg_reg.image_width   <= DIM_REG_W'(32);
            cfg_reg.kernel_height <= KER_REG_W'(3);
            cfg_reg.kernel_width  <= KER_REG_W'(3);
            cfg_reg.pad_rows      <= PAD_REG_W'(1);
            cfg_reg.pad_cols      <= PAD_REG_W'(1);
            cfg_reg.stride_rows   <= STR_REG_W'(1);
            cfg_reg.stride_cols   <= STR_REG_W'(1);
            settle_reg            <= '0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    assign span_h = SPAN_W'(cfg_reg.image_height) + SPAN_W'({cfg_reg.pad_rows, 1'b0});
    assign span_w = SPAN_W'(cfg_reg.image_width) + SPAN_W'({cfg_reg.pad_cols, 1'b0});
    assign ok_next = (cfg_reg.image_height != '0) && (cfg_reg.image_width != '0)
                     && (cfg_reg.kernel_height != '0) && (cfg_reg.kernel_width != '0)
                     && (cfg_reg.stride_rows != '0) && (cfg_reg.stride_cols != '0)
                     && (int'(cfg_reg.kernel_height) <= MAX_KERNEL)
                     && (int'(cfg_reg.kernel_width) <= MAX_KERNEL)
                     && (int'(cfg_reg.image_height) <= MAX_DIM)
                     && (int'(cfg_reg.image_width) <= MAX_DIM)
                     && (span_h >= SPAN_W'(cfg_reg.kernel_height))
                     && (span_w >= SPAN_W'(cfg_reg.kernel_width));
    assign rem_h = CORR_W'(diff_h2_reg)
                   - CORR_W'(q0_h_reg) * CORR_W'(cfg_reg.stride_rows);
    assign rem_w = CORR_W'(diff_w2_reg)
                   - CORR_W'(q0_w_reg) * CORR_W'(cfg_reg.stride_cols);

    always_ff @(posedge clk)
    begin
        diff_h_reg  <= span_h - SPAN_W'(cfg_reg.kernel_height);
        diff_w_reg  <= span_w - SPAN_W'(cfg_reg.kernel_width);
        prod_h_reg  <= PROD_W'(span_h - SPAN_W'(cfg_reg.kernel_height))
                       * PROD_W'(stride_recip(cfg_reg.stride_rows));
        prod_w_reg  <= PROD_W'(span_w - SPAN_W'(cfg_reg.kernel_width))
                       * PROD_W'(stride_recip(cfg_reg.stride_cols));
        ok_reg      <= ok_next;
        taps_reg    <= KK_W'(cfg_reg.kernel_height) * KK_W'(cfg_reg.kernel_width);
        q0_h_reg    <= prod_h_reg[RECIP_SHIFT +: GRID_W];
        q0_w_reg    <= prod_w_reg[RECIP_SHIFT +: GRID_W];
        diff_h2_reg <= diff_h_reg;
        diff_w2_reg <= diff_w_reg;
        out_h_reg   <= q0_h_reg + GRID_W'(1)
                       + GRID_W'(rem_h >= CORR_W'(cfg_reg.stride_rows));
        out_w_reg   <= q0_w_reg + GRID_W'(1)
                       + GRID_W'(rem_w >= CORR_W'(cfg_reg.stride_cols));
        plane_reg   <= PLANE_W'(out_h_reg) * PLANE_W'(out_w_reg);
    end

    always_comb
    begin
        geom.ready = (settle_reg == SET_W'(GEOM_LAT));
        geom.ok    = ok_reg;
        geom.out_h = out_h_reg;
        geom.out_w = out_w_reg;
        geom.plane = plane_reg;
        geom.taps  = taps_reg;
    end

    im2c_front #(.ADDR_WIDTH(ADDR_WIDTH), .ENTRY_W(ENTRY_W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .index_ch   (index_ch),
        .cfg        (cfg_reg),
        .geom       (geom),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_full  (q_full)
    );

    im2c_queue #(.W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    im2c_back #(.ADDR_WIDTH(ADDR_WIDTH), .ENTRY_W(ENTRY_W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (q_empty),
        .pop      (q_pop),
        .cfg      (cfg_reg),
        .geom     (geom),
        .addr_ch  (addr_ch)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("tap walker popped an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (geom.ready && geom.ok) |-> (geom.out_h != '0 && geom.out_w != '0))
        else $error("settled output grid has a zero side");
    assert property (@(posedge clk) disable iff (!rst_n)
        (addr_ch.valid && addr_ch.is_padding) |-> (addr_ch.source_address == '0))
        else $error("padding tap carries a nonzero source address");
    assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> !geom.ready)
        else $error("output grid reported settled right after a register write");
endmodule
